/* rtl/core/masked_first_match_rule_table_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the masked first-match rule table
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MASKED_FIRST_MATCH_RULE_TABLE_ASSERT_SVH
`define MASKED_FIRST_MATCH_RULE_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFMRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MFMRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mfmrt_pkg.sv */
// ---------------------------------------------------------------------------
// mfmrt_pkg
// Shared types, codes and helpers for the masked first-match rule table.
// ---------------------------------------------------------------------------
package mfmrt_pkg;

  // Request kinds
  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Action codes
  localparam logic [1:0] ACT_DISCARD  = 2'd0;
  localparam logic [1:0] ACT_PASS     = 2'd1;
  localparam logic [1:0] ACT_EXAMINE  = 2'd2;
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  typedef enum logic [1:0] {
    STAT_ADDED = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_HIT   = 2'd2,
    STAT_MISS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  // One stored rule; key is held pre-masked
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] mask;
    logic [1:0]  action;
  } rule_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } rule_ctl_t;

  typedef struct packed {
    logic rd_en;
    logic clr_en;
    logic inc_en;
  } cnt_ctl_t;

  // Saturating hit counter increment
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

/* rtl/core/mfmrt_rule_mem.sv */
// ---------------------------------------------------------------------------
// mfmrt_rule_mem
// Rule store: key, mask and action per slot; one write, one registered read.
// ---------------------------------------------------------------------------
module mfmrt_rule_mem #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                clk,
  input  mfmrt_pkg::rule_ctl_t ctl,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
  input  mfmrt_pkg::rule_t    wr_data,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
  output mfmrt_pkg::rule_t    rd_data
);
  import mfmrt_pkg::*;

  rule_t mem [ENTRIES];
  rule_t rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/mfmrt_cnt_mem.sv */
// ---------------------------------------------------------------------------
// mfmrt_cnt_mem
// Hit counter store: clear on add, saturating increment of the last read.
// ---------------------------------------------------------------------------
module mfmrt_cnt_mem #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                clk,
  input  mfmrt_pkg::cnt_ctl_t ctl,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
  output logic [31:0]         rd_data
);
  import mfmrt_pkg::*;

  logic [31:0] mem [ENTRIES];
  logic [31:0] rd_data_r;
  logic [31:0] wr_data;

  // increment writes back the word last read, plus one
  assign wr_data = ctl.clr_en ? 32'd0 : sat_inc(rd_data_r);

  always_ff @(posedge clk) begin
    if (ctl.clr_en || ctl.inc_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/masked_first_match_rule_table.sv */
// An add, or an add refused on a full table, goes straight to the result; a
// lookup scans the held rules from slot 0 up to the first match or the last
// rule (the scan reads one rule per cycle), then hands over its result.
// One request in flight; the next is accepted at the soonest on the edge after
// out_valid rises. A stalled result delays the hand-over to the output register.
// Reset (rst_n low, synchronous) empties the table and drops any result.
// ---------------------------------------------------------------------------
// masked_first_match_rule_table
// Append-only masked rule table with first-match lookup and saturating
// per-rule hit counters, built around two single-port-pair memories.
// ---------------------------------------------------------------------------
`include "masked_first_match_rule_table_assert.svh"

module masked_first_match_rule_table #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [31:0] in_address_value,
  input  logic [31:0] in_mask_value,
  input  logic [1:0]  in_rule_action,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [1:0]  out_action,
  output logic [5:0]  out_entry_index,
  output logic [31:0] out_hit_total
);
  import mfmrt_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  // Slot number as carried on the result: low six bits only
  function automatic logic [5:0] low6(input logic [IDX_W-1:0] v);
    logic [IDX_W+5:0] w;
    w = {6'b0, v};
    return w[5:0];
  endfunction

  // -------------------------------------------------------------------------
  // State
  // -------------------------------------------------------------------------
  state_t           state_r,     state_nxt;
  logic [CNT_W-1:0] count_r,     count_nxt;   // rules added; slots below are valid
  logic [CNT_W-1:0] rd_ptr_r,    rd_ptr_nxt;  // next slot to read in the scan
  logic [IDX_W-1:0] cmp_idx_r,   cmp_idx_nxt; // slot whose data is on the read port
  logic             pend_r,      pend_nxt;    // read data is live this cycle
  logic [31:0]      addr_r,      addr_nxt;    // lookup address under test

  // pending result, waiting for the output register
  logic [1:0]       res_status_r, res_status_nxt;
  logic [1:0]       res_action_r, res_action_nxt;
  logic [5:0]       res_index_r,  res_index_nxt;
  logic [31:0]      res_hits_r,   res_hits_nxt;

  // output register
  logic             out_valid_r,  out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [1:0]       out_action_r, out_action_nxt;
  logic [5:0]       out_index_r,  out_index_nxt;
  logic [31:0]      out_hits_r,   out_hits_nxt;

  // memory ports
  rule_ctl_t        rule_ctl;
  logic [IDX_W-1:0] rule_wr_addr;
  rule_t            rule_wr_data;
  logic [IDX_W-1:0] rule_rd_addr;
  rule_t            rule_rd_data;

  cnt_ctl_t         cnt_ctl;
  logic [IDX_W-1:0] cnt_wr_addr;
  logic [IDX_W-1:0] cnt_rd_addr;
  logic [31:0]      cnt_rd_data;

  logic             in_acc;
  logic             match;
  logic             table_full;

  // assertion terms
  logic             cnt_wr_en;
  logic             add_acc;
  logic             hit_out;

  // -------------------------------------------------------------------------
  // Memories
  // -------------------------------------------------------------------------
  mfmrt_rule_mem #(.ENTRIES(ENTRIES)) u_rule_mem (
    .clk     (clk),
    .ctl     (rule_ctl),
    .wr_addr (rule_wr_addr),
    .wr_data (rule_wr_data),
    .rd_addr (rule_rd_addr),
    .rd_data (rule_rd_data)
  );

  mfmrt_cnt_mem #(.ENTRIES(ENTRIES)) u_cnt_mem (
    .clk     (clk),
    .ctl     (cnt_ctl),
    .wr_addr (cnt_wr_addr),
    .rd_addr (cnt_rd_addr),
    .rd_data (cnt_rd_data)
  );

  // -------------------------------------------------------------------------
  // Handshake and compare
  // -------------------------------------------------------------------------
  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign table_full = (count_r == CNT_W'(ENTRIES));

  // key is stored pre-masked, so only the address needs masking here
  assign match = pend_r && ((addr_r & rule_rd_data.mask) == rule_rd_data.key);

  // Rule write data: undefined action code three is stored as drop
  always_comb begin
    rule_wr_data.key    = in_address_value & in_mask_value;
    rule_wr_data.mask   = in_mask_value;
    rule_wr_data.action = (in_rule_action == ACT_RESERVED) ? ACT_DISCARD : in_rule_action;
  end

  // Both memories are read at the scan pointer, so the counter for a
  // matching slot arrives alongside its rule. The sequencer never reads and
  // writes in the same cycle: writes happen on the accept of an add and on
  // the cycle a match is found, and the scan stops there.
  assign rule_rd_addr = rd_ptr_r[IDX_W-1:0];
  assign cnt_rd_addr  = rd_ptr_r[IDX_W-1:0];
  assign rule_wr_addr = count_r[IDX_W-1:0];

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_ptr_nxt     = rd_ptr_r;
    cmp_idx_nxt    = cmp_idx_r;
    pend_nxt       = 1'b0;
    addr_nxt       = addr_r;
    res_status_nxt = res_status_r;
    res_action_nxt = res_action_r;
    res_index_nxt  = res_index_r;
    res_hits_nxt   = res_hits_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_action_nxt = out_action_r;
    out_index_nxt  = out_index_r;
    out_hits_nxt   = out_hits_r;
    rule_ctl       = '0;
    cnt_ctl        = '0;
    cnt_wr_addr    = count_r[IDX_W-1:0];

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_ADD) begin
            res_action_nxt = ACT_DISCARD;
            res_hits_nxt   = 32'd0;
            if (table_full) begin
              res_status_nxt = STAT_FULL;
              res_index_nxt  = 6'd0;
            end else begin
              rule_ctl.wr_en = 1'b1;
              cnt_ctl.clr_en = 1'b1;
              count_nxt      = count_r + CNT_W'(1);
              res_status_nxt = STAT_ADDED;
              res_index_nxt  = low6(count_r[IDX_W-1:0]);
            end
            state_nxt = S_EMIT;
          end else begin
            addr_nxt   = in_address_value;
            rd_ptr_nxt = '0;
            state_nxt  = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (match) begin
          // first match wins: bump its counter and report
          cnt_ctl.inc_en = 1'b1;
          cnt_wr_addr    = cmp_idx_r;
          res_status_nxt = STAT_HIT;
          res_action_nxt = rule_rd_data.action;
          res_index_nxt  = low6(cmp_idx_r);
          res_hits_nxt   = sat_inc(cnt_rd_data);
          state_nxt      = S_EMIT;
        end else if (rd_ptr_r < count_r) begin
          rule_ctl.rd_en = 1'b1;
          cnt_ctl.rd_en  = 1'b1;
          cmp_idx_nxt    = rd_ptr_r[IDX_W-1:0];
          rd_ptr_nxt     = rd_ptr_r + CNT_W'(1);
          pend_nxt       = 1'b1;
        end else begin
          res_status_nxt = STAT_MISS;
          res_action_nxt = ACT_DISCARD;
          res_index_nxt  = 6'd0;
          res_hits_nxt   = 32'd0;
          state_nxt      = S_EMIT;
        end
      end

      S_EMIT: begin
        // hand over once the output register is free or being emptied
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_action_nxt = res_action_r;
          out_index_nxt  = res_index_r;
          out_hits_nxt   = res_hits_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    rd_ptr_r     <= rd_ptr_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    addr_r       <= addr_nxt;
    res_status_r <= res_status_nxt;
    res_action_r <= res_action_nxt;
    res_index_r  <= res_index_nxt;
    res_hits_r   <= res_hits_nxt;
    out_status_r <= out_status_nxt;
    out_action_r <= out_action_nxt;
    out_index_r  <= out_index_nxt;
    out_hits_r   <= out_hits_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_action      = out_action_r;
  assign out_entry_index = out_index_r;
  assign out_hit_total   = out_hits_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  assign cnt_wr_en = cnt_ctl.clr_en || cnt_ctl.inc_en;
  assign add_acc   = in_acc && (in_kind == KIND_ADD);
  assign hit_out   = out_valid_r && (out_status_r == STAT_HIT);

  `MFMRT_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(ENTRIES), "rule count past size")
  `MFMRT_ASSERT_NOW(a_cnt_port_excl, cnt_ctl.rd_en, !cnt_wr_en, "counter read and write overlap")
  `MFMRT_ASSERT_NEXT(a_add_to_emit, add_acc, state_r == S_EMIT, "add took over a cycle")
  `MFMRT_ASSERT_NOW(a_hit_nonzero, hit_out, out_hits_r != 32'd0, "hit with zero count")

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - masked first-match rule table
// Drives add and lookup requests, predicts each result from a private copy
// of the table, and compares every returned result field by field.
// ---------------------------------------------------------------------------
module tb;
  import mfmrt_pkg::*;

  localparam int unsigned ENTRIES      = 64;
  localparam int unsigned RANDOM_ITEMS = 452;  // split over four idling phases
  localparam int unsigned DRAIN_CYCLES = ENTRIES + 16;  // beyond the slowest miss

  // One request as it goes onto the input channel
  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [1:0]  act;
  } request_t;

  // One result as it comes off the result channel
  typedef struct packed {
    status_t     status;
    logic [1:0]  action;
    logic [5:0]  slot;
    logic [31:0] hits;
  } outcome_t;

  // Directed row: request plus, where it is obvious, the result typed in
  typedef struct packed {
    request_t req;
    bit       typed;
    outcome_t want;
  } plan_row_t;

  // Clock, reset and block inputs, all known from time zero
  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_kind          = KIND_ADD;
  logic [31:0] in_address_value = '0;
  logic [31:0] in_mask_value    = '0;
  logic [1:0]  in_rule_action   = ACT_DISCARD;
  logic        out_stall        = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [1:0]  out_action;
  logic [5:0]  out_entry_index;
  logic [31:0] out_hit_total;

  // Private copy of the rule table
  logic [31:0] rule_key  [ENTRIES];
  logic [31:0] rule_mask [ENTRIES];
  logic [1:0]  rule_act  [ENTRIES];
  bit          rule_live [ENTRIES];
  logic [31:0] rule_hits [ENTRIES];
  int unsigned rules_held = 0;

  outcome_t    outcomes_due[$];
  plan_row_t   directed_plan[$];

  // Idling percentages, changed per phase
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  // Run statistics
  int unsigned mismatches = 0;
  int unsigned n_added    = 0;
  int unsigned n_full     = 0;
  int unsigned n_hit      = 0;
  int unsigned n_miss     = 0;
  int unsigned deepest    = 0;

  masked_first_match_rule_table #(
    .ENTRIES (ENTRIES)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_address_value (in_address_value),
    .in_mask_value    (in_mask_value),
    .in_rule_action   (in_rule_action),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_action       (out_action),
    .out_entry_index  (out_entry_index),
    .out_hit_total    (out_hit_total)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (~470 deep scans with stalls)
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // Predict the result of one accepted request and update the table copy.
  // Add: append at the next free slot, or refuse when full.
  // Lookup: lowest valid slot whose masked key equals the masked address.
  function automatic outcome_t classify_request(input request_t r);
    outcome_t v;
    bit       found;
    v.status = STAT_MISS;
    v.action = ACT_DISCARD;
    v.slot   = '0;
    v.hits   = '0;
    found    = 1'b0;
    if (r.kind == KIND_ADD) begin
      if (rules_held >= ENTRIES) begin
        v.status = STAT_FULL;
      end else begin
        rule_key[rules_held]  = r.addr;
        rule_mask[rules_held] = r.mask;
        // undefined action code is stored as drop
        rule_act[rules_held]  = (r.act == ACT_RESERVED) ? ACT_DISCARD : r.act;
        rule_hits[rules_held] = '0;
        rule_live[rules_held] = 1'b1;
        v.status = STAT_ADDED;
        v.slot   = 6'(rules_held);
        rules_held++;
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && rule_live[i] &&
            ((r.addr & rule_mask[i]) == (rule_key[i] & rule_mask[i]))) begin
          found = 1'b1;
          if (rule_hits[i] != '1)  // counter saturates
            rule_hits[i] = rule_hits[i] + 32'd1;
          v.status = STAT_HIT;
          v.action = rule_act[i];
          v.slot   = 6'(i);
          v.hits   = rule_hits[i];
        end
      end
    end
    return v;
  endfunction

  // Random request. Roughly one in five is an add, so the table fills part
  // way through and later adds are refused. Most lookups are aimed into
  // the space of a stored rule; the rest are random addresses.
  function automatic request_t draw_request();
    request_t    r;
    int unsigned pick;
    int unsigned len;
    r.addr = $urandom;
    r.mask = $urandom;
    r.act  = 2'($urandom_range(3));
    if ($urandom_range(4) == 0) begin
      r.kind = KIND_ADD;
      case ($urandom_range(9))
        0: r.mask = '1;
        1, 2, 3, 4: begin
          len    = $urandom_range(32, 12);
          r.mask = ~(32'hFFFF_FFFF >> len);
        end
        default: ;
      endcase
      // last slot becomes a catch-all, default-route style
      if (rules_held == ENTRIES - 1)
        r.mask = '0;
    end else begin
      r.kind = KIND_LOOKUP;
      if (rules_held != 0 && $urandom_range(3) != 0) begin
        pick   = $urandom_range(rules_held - 1);
        r.addr = (rule_key[pick] & rule_mask[pick]) | (r.addr & ~rule_mask[pick]);
      end
    end
    return r;
  endfunction

  task automatic plan_request(input logic kind, input logic [31:0] addr,
                              input logic [31:0] mask, input logic [1:0] act,
                              input bit typed, input status_t st,
                              input logic [1:0] ac, input logic [5:0] slot,
                              input logic [31:0] hits);
    plan_row_t p;
    p.req.kind    = kind;
    p.req.addr    = addr;
    p.req.mask    = mask;
    p.req.act     = act;
    p.typed       = typed;
    p.want.status = st;
    p.want.action = ac;
    p.want.slot   = slot;
    p.want.hits   = hits;
    directed_plan.push_back(p);
  endtask

  // Present one request at the falling edge and hold it until accepted.
  // Entered and left at a falling edge; valid is left high on return.
  task automatic send_request(input request_t r, input bit typed, input outcome_t want);
    outcome_t v;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= r.kind;
    in_address_value <= r.addr;
    in_mask_value    <= r.mask;
    in_rule_action   <= r.act;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge: the table copy moves on now
    v = classify_request(r);
    outcomes_due.push_back(typed ? want : v);
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, exp);
    mismatches++;
  endtask

  // Result receiver: random stall, independent of valid
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Result checker: compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch("unrequested result, status", 32'(out_status), '0);
      end else begin
        want = outcomes_due.pop_front();
        if (out_status != want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_action != want.action)
          report_mismatch("action", 32'(out_action), 32'(want.action));
        if (out_entry_index != want.slot)
          report_mismatch("entry index", 32'(out_entry_index), 32'(want.slot));
        if (out_hit_total != want.hits)
          report_mismatch("hit total", out_hit_total, want.hits);
        case (want.status)
          STAT_ADDED: n_added++;
          STAT_FULL:  n_full++;
          STAT_HIT: begin
            n_hit++;
            if (32'(want.slot) > deepest) deepest = 32'(want.slot);
          end
          default:    n_miss++;
        endcase
      end
    end
  end

  initial begin
    outcome_t none;
    none = '0;

    // -- directed requests ---------------------------------------------------
    // empty table: every lookup misses; mask and action on a lookup are don't-care
    plan_request(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, ACT_DISCARD,
                 1'b1, STAT_MISS, ACT_DISCARD, 6'd0, 32'd0);
    plan_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ACT_RESERVED,
                 1'b1, STAT_MISS, ACT_DISCARD, 6'd0, 32'd0);
    // rules land in slots 0, 1, ... in order; adds report no action or hits
    plan_request(KIND_ADD, 32'h0A00_0000, 32'hFF00_0000, ACT_PASS,
                 1'b1, STAT_ADDED, ACT_DISCARD, 6'd0, 32'd0);
    plan_request(KIND_ADD, 32'hC0A8_0100, 32'hFFFF_FF00, ACT_EXAMINE,
                 1'b1, STAT_ADDED, ACT_DISCARD, 6'd1, 32'd0);
    plan_request(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ACT_DISCARD,
                 1'b1, STAT_ADDED, ACT_DISCARD, 6'd2, 32'd0);
    // undefined action code: kept as drop
    plan_request(KIND_ADD, 32'h0000_0000, 32'hFFFF_FFFF, ACT_RESERVED,
                 1'b1, STAT_ADDED, ACT_DISCARD, 6'd3, 32'd0);
    // sits under slot 0, so never wins
    plan_request(KIND_ADD, 32'h0A01_0000, 32'hFFFF_0000, ACT_EXAMINE,
                 1'b0, STAT_ADDED, ACT_DISCARD, 6'd0, 32'd0);
    plan_request(KIND_ADD, 32'h5A5A_5A5A, 32'hF0F0_F0F0, ACT_PASS,
                 1'b0, STAT_ADDED, ACT_DISCARD, 6'd0, 32'd0);
    // key bits outside the mask are irrelevant
    plan_request(KIND_ADD, 32'hDEAD_BEEF, 32'h0000_FFFF, ACT_EXAMINE,
                 1'b0, STAT_ADDED, ACT_DISCARD, 6'd0, 32'd0);
    plan_request(KIND_LOOKUP, 32'h0A12_3456, 32'h0000_0000, ACT_DISCARD,
                 1'b1, STAT_HIT, ACT_PASS, 6'd0, 32'd1);
    // first match wins over the narrower rule in slot 4
    plan_request(KIND_LOOKUP, 32'h0A01_FFFF, 32'hFFFF_FFFF, ACT_RESERVED,
                 1'b0, STAT_MISS, ACT_DISCARD, 6'd0, 32'd0);
    plan_request(KIND_LOOKUP, 32'hC0A8_01FF, 32'h1234_5678, ACT_EXAMINE,
                 1'b0, STAT_MISS, ACT_DISCARD, 6'd0, 32'd0);
    plan_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, ACT_PASS,
                 1'b0, STAT_MISS, ACT_DISCARD, 6'd0, 32'd0);
    plan_request(KIND_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, ACT_DISCARD,
                 1'b0, STAT_MISS, ACT_DISCARD, 6'd0, 32'd0);
    plan_request(KIND_LOOKUP, 32'h5F5A_5F5A, 32'hA5A5_A5A5, ACT_RESERVED,
                 1'b0, STAT_MISS, ACT_DISCARD, 6'd0, 32'd0);
    plan_request(KIND_LOOKUP, 32'h1234_BEEF, 32'h0000_0000, ACT_DISCARD,
                 1'b0, STAT_MISS, ACT_DISCARD, 6'd0, 32'd0);
    plan_request(KIND_LOOKUP, 32'hC0A8_0200, 32'hFFFF_0000, ACT_PASS,
                 1'b0, STAT_MISS, ACT_DISCARD, 6'd0, 32'd0);
    plan_request(KIND_LOOKUP, 32'h0B00_0000, 32'h0000_0000, ACT_DISCARD,
                 1'b0, STAT_MISS, ACT_DISCARD, 6'd0, 32'd0);
    plan_request(KIND_LOOKUP, 32'h0A00_0000, 32'h0000_0000, ACT_DISCARD,
                 1'b0, STAT_MISS, ACT_DISCARD, 6'd0, 32'd0);

    // -- reset: held from time zero, released on a falling edge -----------------
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_plan[i])
      send_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].want);

    // -- random requests in four idling phases --------------------------------
    for (int ph = 0; ph < 4; ph++) begin
      // hold off until the block has answered everything outstanding
      in_valid <= 1'b0;
      @(negedge clk);
      while (outcomes_due.size() != 0) @(negedge clk);
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      repeat (RANDOM_ITEMS / 4) send_request(draw_request(), 1'b0, none);
    end

    // -- drain -----------------------------------------------------------------
    in_valid <= 1'b0;
    @(negedge clk);
    while (outcomes_due.size() != 0) @(negedge clk);
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d requests: %0d rules added, %0d adds refused on a full table",
             n_added + n_full + n_hit + n_miss, n_added, n_full);
    $display("lookups: %0d hits (deepest slot %0d), %0d misses; %0d mismatches",
             n_hit, deepest, n_miss, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
